// ===== rtl/sida_pkg.sv =====
package sida_pkg;

   // Default operand width and fixed field widths
   localparam int DATA_WIDTH_DEF = 32;
   localparam int VALUE_WIDTH    = 32;
   localparam int CHAR_WIDTH     = 6;
   localparam int RSP_DATA_WIDTH = 8;

   // Character codes
   localparam logic [CHAR_WIDTH-1:0] ASCII_ZERO  = 6'd48;
   localparam logic [CHAR_WIDTH-1:0] ASCII_MINUS = 6'd45;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;       // capture a new item and start conversion
      logic conv_step;  // one shift-add-3 step
      logic shift;      // drop the top BCD digit
      logic sel_sign;   // present the minus sign instead of a digit
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic negative;   // item was negative
      logic bit_last;   // final conversion step in progress
      logic top_zero;   // top BCD digit is zero
      logic one_left;   // only one digit left to print
   } status_type;

endpackage

// ===== rtl/sida_dp.sv =====
module sida_dp #(
   parameter int DATA_WIDTH = sida_pkg::DATA_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [sida_pkg::VALUE_WIDTH-1:0]    value,
   input  sida_pkg::cmd_type                   cmd,
   output sida_pkg::status_type                status,
   output logic [sida_pkg::CHAR_WIDTH-1:0]     char_code
);
   import sida_pkg::*;

   // Decimal digits of the largest magnitude, 2^(DATA_WIDTH-1)
   localparam int NumDigits = ((DATA_WIDTH - 1) * 30103) / 100000 + 1;
   localparam int BcdWidth  = 4 * NumDigits;
   localparam int BitCntW   = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;
   localparam int DigCntW   = $clog2(NumDigits + 1);

   logic [DATA_WIDTH-1:0] raw;
   logic [DATA_WIDTH-1:0] mag_ff, mag_in;
   logic [BcdWidth-1:0]   bcd_ff, bcd_in, bcd_adj;
   logic                  neg_ff, neg_in;
   logic [BitCntW-1:0]    bit_cnt_ff, bit_cnt_in;
   logic [DigCntW-1:0]    dig_left_ff, dig_left_in;
   logic [3:0]            top_digit;

   // Operand: low DATA_WIDTH bits, sign extended when wider than the field
   if (DATA_WIDTH <= VALUE_WIDTH) begin : g_narrow
      assign raw = value[DATA_WIDTH-1:0];
   end else begin : g_wide
      assign raw = {{(DATA_WIDTH - VALUE_WIDTH){value[VALUE_WIDTH-1]}}, value};
   end

   // Add 3 to every BCD digit of 5 or more
   always_comb begin
      for (int i = 0; i < NumDigits; i++) begin
         if (bcd_ff[4*i +: 4] >= 4'd5) begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4] + 4'd3;
         end else begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4];
         end
      end
   end

   // Next-state logic
   always_comb begin
      mag_in      = mag_ff;
      bcd_in      = bcd_ff;
      neg_in      = neg_ff;
      bit_cnt_in  = bit_cnt_ff;
      dig_left_in = dig_left_ff;
      if (cmd.load) begin
         neg_in      = raw[DATA_WIDTH-1];
         mag_in      = raw[DATA_WIDTH-1] ? (~raw + DATA_WIDTH'(1)) : raw;
         bcd_in      = '0;
         bit_cnt_in  = BitCntW'(DATA_WIDTH - 1);
         dig_left_in = DigCntW'(NumDigits);
      end else if (cmd.conv_step) begin
         {bcd_in, mag_in} = {bcd_adj, mag_ff} << 1;
         bit_cnt_in       = bit_cnt_ff - BitCntW'(1);
      end else if (cmd.shift) begin
         bcd_in      = bcd_ff << 4;
         dig_left_in = dig_left_ff - DigCntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_cnt_ff  <= '0;
         dig_left_ff <= '0;
         neg_ff      <= 1'b0;
         mag_ff      <= '0;
         bcd_ff      <= '0;
      end else begin
         bit_cnt_ff  <= bit_cnt_in;
         dig_left_ff <= dig_left_in;
         neg_ff      <= neg_in;
         mag_ff      <= mag_in;
         bcd_ff      <= bcd_in;
      end
   end

   // Status and character
   assign top_digit       = bcd_ff[BcdWidth-1 -: 4];
   assign status.negative = neg_ff;
   assign status.bit_last = (bit_cnt_ff == '0);
   assign status.top_zero = (top_digit == 4'd0);
   assign status.one_left = (dig_left_ff == DigCntW'(1));
   assign char_code       = cmd.sel_sign ? ASCII_MINUS : (ASCII_ZERO + {2'b00, top_digit});

endmodule

// ===== rtl/sida_ctrl.sv =====
module sida_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_last,
   input  sida_pkg::status_type status,
   output sida_pkg::cmd_type    cmd
);
   import sida_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_CONV  = 5'b00010,
      S_SKIP  = 5'b00100,
      S_SIGN  = 5'b01000,
      S_DIGIT = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   // Sequencer: accept, convert, skip leading zeros, emit sign and digits
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      rsp_last  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_CONV;
            end
         end
         S_CONV: begin
            cmd.conv_step = 1'b1;
            if (status.bit_last) begin
               state_in = S_SKIP;
            end
         end
         S_SKIP: begin
            if (status.top_zero && !status.one_left) begin
               cmd.shift = 1'b1;
            end else if (status.negative) begin
               state_in = S_SIGN;
            end else begin
               state_in = S_DIGIT;
            end
         end
         S_SIGN: begin
            rsp_valid    = 1'b1;
            cmd.sel_sign = 1'b1;
            if (rsp_ready) begin
               state_in = S_DIGIT;
            end
         end
         S_DIGIT: begin
            rsp_valid = 1'b1;
            rsp_last  = status.one_left;
            if (rsp_ready) begin
               cmd.shift = 1'b1;
               if (status.one_left) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/signed_int_to_decimal_ascii.sv =====
// Signed integer to decimal text. Each item on req_ carries one two's-complement
// value (low DATA_WIDTH bits used); the block returns its decimal ASCII text on
// rsp_, one character per item: a '-' for negative values, then every digit from
// the most significant one with leading zeros suppressed ("0" for zero), tlast on
// the final character. The most negative value prints exactly. One number is in
// flight at a time: after acceptance a double-dabble loop converts the value one
// bit per step, a scan then drops the leading zeros one digit per step, and the
// characters go out in order, each held while rsp_tready is low. Suppressed zeros
// and printed digits always add up to the BCD digits, ten at the default width.
module signed_int_to_decimal_ascii #(
   parameter int DATA_WIDTH = sida_pkg::DATA_WIDTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [sida_pkg::VALUE_WIDTH-1:0]     req_tdata,   // [31:0] value
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [sida_pkg::RSP_DATA_WIDTH-1:0]  rsp_tdata,   // [5:0] char_code, [7:6] zero
   output logic                                 rsp_tlast    // last
);
   import sida_pkg::*;

   cmd_type                 cmd;
   status_type              status;
   logic [CHAR_WIDTH-1:0]   char_code;

   sida_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_last  (rsp_tlast),
      .status    (status),
      .cmd       (cmd)
   );

   sida_dp #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .value     (req_tdata),
      .cmd       (cmd),
      .status    (status),
      .char_code (char_code)
   );

   assign rsp_tdata = {{(RSP_DATA_WIDTH - CHAR_WIDTH){1'b0}}, char_code};

endmodule

// ===== rtl/sida_checker.sv =====
module sida_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast
);

   // Stalled output holds its character
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast)))
      else $error("stalled output item changed");

   // No new number is taken while text is going out
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("input ready while output pending");

   // Only a minus sign or a digit ever leaves the block
   a_char_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[7:6] == 2'b00) &&
                     ((rsp_tdata[5:0] == 6'd45) ||
                      ((rsp_tdata[5:0] >= 6'd48) && (rsp_tdata[5:0] <= 6'd57))))
      else $error("invalid character code");

   // A minus sign is never the final character
   a_sign_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[5:0] == 6'd45)) |-> !rsp_tlast)
      else $error("minus sign marked last");

   // After the last character the output goes quiet and input reopens
   a_end_of_number: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> (!rsp_tvalid && req_tready))
      else $error("output continued after last character");

endmodule

bind signed_int_to_decimal_ascii sida_checker u_sida_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

// ===== tb/signed_int_to_decimal_ascii_test.sv =====
module signed_int_to_decimal_ascii_test;
   import sida_pkg::*;

   localparam int RANDOM_ITEMS = 407;
   localparam int DRAIN_CYCLES = 80;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [VALUE_WIDTH-1:0]    req_tdata = '0;     // [31:0] value
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;          // [5:0] char_code, [7:6] zero
   logic                      rsp_tlast;          // last

   // when set, neither side inserts wait cycles
   bit steady = 1'b0;

   // Expected text of every accepted number, one character per entry
   class char_scoreboard;
      typedef struct {
         logic [CHAR_WIDTH-1:0] code;
         logic                  last;
      } char_type;

      char_type pending[$];
      int       mismatches = 0;
      // mirror of the block's state after the last number
      logic [31:0] last_magnitude = '0;
      logic [3:0]  last_digit_count = '0;
      logic        last_negative = 1'b0;

      // work out the text of one accepted value
      function void note_value(logic [VALUE_WIDTH-1:0] value);
         logic [31:0]     magnitude;
         longint unsigned rest;
         byte unsigned    digits[$];
         char_type        c;
         last_negative  = value[VALUE_WIDTH-1];
         // unsigned negation keeps the most negative value exact
         magnitude      = last_negative ? (~value + 32'd1) : value;
         last_magnitude = magnitude;
         rest           = 64'(magnitude);
         do begin
            digits.push_front(byte'(rest % 10));
            rest = rest / 10;
         end while (rest != 0);
         last_digit_count = 4'(digits.size());
         if (last_negative) begin
            c.code = ASCII_MINUS;
            c.last = 1'b0;
            pending.push_back(c);
         end
         foreach (digits[i]) begin
            c.code = ASCII_ZERO + CHAR_WIDTH'(digits[i]);
            c.last = (i == digits.size() - 1);
            pending.push_back(c);
         end
      endfunction

      // compare one accepted character with the oldest expectation
      function void check_char(logic [RSP_DATA_WIDTH-1:0] data, logic tlast);
         char_type c;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected character: data=%h last=%b", data, tlast);
            return;
         end
         c = pending.pop_front();
         if (data !== {{(RSP_DATA_WIDTH-CHAR_WIDTH){1'b0}}, c.code} || tlast !== c.last) begin
            mismatches++;
            if (mismatches <= 10)
               $display("character mismatch: expected data=%h last=%b, got data=%h last=%b",
                        {{(RSP_DATA_WIDTH-CHAR_WIDTH){1'b0}}, c.code}, c.last, data, tlast);
         end
      endfunction

      function int outstanding();
         return pending.size();
      endfunction
   endclass

   char_scoreboard board;

   signed_int_to_decimal_ascii dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   // Offer one value and wait until it is accepted
   task automatic send_value(input logic [VALUE_WIDTH-1:0] value);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         req_tdata  <= $urandom();   // noise while idle
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
      board.note_value(value);
   endtask

   // Accept characters forever, stalling at random
   task automatic receive_chars();
      int gap;
      forever begin
         gap = steady ? 0 : $urandom_range(0, 3);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         board.check_char(rsp_tdata, rsp_tlast);
      end
   endtask

   function automatic longint unsigned pow10(int n);
      longint unsigned p;
      p = 64'd1;
      repeat (n) p = p * 64'd10;
      return p;
   endfunction

   // Random value: raw bits, a chosen digit count, trailing zeros, or small
   function automatic logic [VALUE_WIDTH-1:0] draw_value();
      int              kind;
      int              ndigits;
      longint unsigned lo;
      longint unsigned span;
      longint unsigned magnitude;
      bit              negative;
      kind     = $urandom_range(0, 3);
      negative = 1'($urandom_range(0, 1));
      if (kind == 0)
         return $urandom();
      if (kind == 3)
         magnitude = 64'($urandom_range(0, 120));
      else begin
         ndigits   = $urandom_range(1, 10);
         lo        = (ndigits == 1) ? 64'd0 : pow10(ndigits - 1);
         span      = pow10(ndigits) - lo;
         magnitude = lo + ({$urandom(), $urandom()} % span);
         if (kind == 2)
            magnitude = magnitude - magnitude % pow10($urandom_range(1, ndigits));
      end
      if (negative) begin
         if (magnitude > 64'd2147483648) magnitude = 64'd2147483648;
         return 32'(-magnitude);
      end
      if (magnitude > 64'd2147483647) magnitude = 64'd2147483647;
      return 32'(magnitude);
   endfunction

   // Main sequence
   initial begin
      int corner_values[$];
      board = new();
      corner_values = '{0, 1, -1, 9, -9, 10, -10, 100, -100, 10000, 12345, -120,
                        999999999, -999999999, 1000000000, -1000000000, 1000000007,
                        2147483647, -2147483647, 32'h8000_0000, 32'h5555_5555,
                        32'hAAAA_AAAA, 2000000000};
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      fork
         receive_chars();
      join_none

      // corner values, first with both sides at full rate
      steady = 1'b1;
      foreach (corner_values[i]) begin
         if (i == 8) steady = 1'b0;
         send_value(corner_values[i]);
      end

      // random values; some stretches run without idle cycles
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 40 == 0) steady = ($urandom_range(0, 3) == 0);
         send_value(draw_value());
      end
      req_tvalid <= 1'b0;

      while (board.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.mismatches == 0)
         $display("[signed_int_to_decimal_ascii] OK");
      else
         $display("[signed_int_to_decimal_ascii] ERROR");
      $finish;
   end

   // Watchdog
   initial begin
      #4000000;
      $display("[signed_int_to_decimal_ascii] ERROR");
      $finish;
   end

endmodule
